// ----- rtl/smsd_pkg.sv -----
// smsd_pkg: shared types and fixed field widths of the sliding median spike detector
// no dependencies; imported by the top level and the bin cell
`timescale 1ns / 1ps

package smsd_pkg;

    localparam int CFG_W    = 11;
    localparam int SAMPLE_W = 8;
    localparam int TWICE_W  = 9;
    localparam int TOTAL_W  = 32;

    // one-hot sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } smsd_state_t;

    // controls from the scan head to every bin cell
    typedef struct packed {
        logic clear;
        logic shift;
    } smsd_cell_ctrl_t;

endpackage

// ----- rtl/smsd_ram.sv -----
// smsd_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module smsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/smsd_cell.sv -----
// smsd_cell: one histogram bin count in the rotating bin chain
// depends on smsd_pkg for the cell control struct
`timescale 1ns / 1ps

module smsd_cell
    import smsd_pkg::*;
#(
    parameter int CNT_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  smsd_cell_ctrl_t  ctrl,
    input  logic [CNT_W-1:0] cnt_in,
    output logic [CNT_W-1:0] cnt_out
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.clear) begin
            cnt_next = '0;
        end else if (ctrl.shift) begin
            cnt_next = cnt_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt_out = cnt_reg;

endmodule

// ----- rtl/sliding_median_spike_detector.sv -----
// sliding_median_spike_detector: flags samples at or above twice the running window median
// depends on smsd_pkg, smsd_cell (histogram bin chain) and smsd_ram (sample ring)
`timescale 1ns / 1ps

//  channel   direction  signals                                        transfer when
//  s_        in         s_sample                                       s_valid & s_ready
//  m_        out        m_window_full m_alert m_twice_median           m_valid & m_ready
//                       m_alert_total
//  cfg_      in         cfg_wr_data (window_length)                    cfg_wr_en
//
//  each sample passes through the accept cycle, one full rotation of the bin chain past
//  the scan head (one bin per cycle), and the retire cycle that loads the result
//  the rotation of the histogram cells is what sets the item period
//  s_ready is high only while idle; the result sits in an output register, so the next
//  sample is taken while an earlier result still waits; a full output register holds
//  the sequencer in its retire cycle
//  aresetn (synchronous) and any config write clear the histogram, pointer, fill level
//  and alert count; no clearing pass is needed

module sliding_median_spike_detector
    import smsd_pkg::*;
#(
    parameter int VALUE_BINS = 256,
    parameter int MAX_WINDOW = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_window_full,
    output logic                m_alert,
    output logic [TWICE_W-1:0]  m_twice_median,
    output logic [TOTAL_W-1:0]  m_alert_total
);

    // widths that follow from the parameters
    localparam int BIN_W = $clog2(VALUE_BINS);
    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = LEN_W;
    localparam int ACC_W = LEN_W + 1;
    localparam int SUM_W = BIN_W + 1;

    // ---------------------------------------------------------------- state
    smsd_state_t          state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [LEN_W-1:0]     fill_reg, fill_next;
    logic [TOTAL_W-1:0]   cnt_reg, cnt_next;

    // per-item working registers
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [BIN_W-1:0]     bin_reg, bin_next;
    logic                 full_reg, full_next;
    logic [BIN_W-1:0]     k_reg, k_next;       // bin index at the scan head
    logic [ACC_W-1:0]     acc_reg, acc_next;   // running cumulative count
    logic                 got_lo_reg, got_lo_next;
    logic                 got_hi_reg, got_hi_next;
    logic [BIN_W-1:0]     lo_reg, lo_next;
    logic [BIN_W-1:0]     hi_reg, hi_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 m_full_reg, m_full_next;
    logic                 m_alert_reg, m_alert_next;
    logic [TWICE_W-1:0]   m_twice_reg, m_twice_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;

    // ---------------------------------------------------------------- datapath signals
    logic                 s_xfer;
    logic                 out_free;
    logic [31:0]          cfg_val;
    logic [ACC_W-1:0]     rank_lo;
    logic [ACC_W-1:0]     rank_hi;
    logic [BIN_W-1:0]     s_bin;
    logic [BIN_W-1:0]     old_bin;
    logic [CNT_W-1:0]     head_cnt;    // count leaving the end of the chain
    logic [CNT_W-1:0]     head_dec;
    logic [CNT_W-1:0]     head_wr;     // updated count fed back into the chain
    logic                 is_new;
    logic                 is_old;
    logic [ACC_W-1:0]     acc_sum;
    logic [SUM_W-1:0]     med_sum;
    logic [SUM_W+8:0]     med_sum_ext;
    logic [SUM_W+7:0]     samp_cmp;
    logic [SUM_W+7:0]     sum_cmp;
    logic                 hit;
    logic [LEN_W-1:0]     ptr_inc;
    logic                 ram_wr_en;
    smsd_cell_ctrl_t      cell_ctrl;

    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // ranks of the lower and upper middle values
    assign rank_lo = (ACC_W'(len_reg) + ACC_W'(1)) >> 1;
    assign rank_hi = ACC_W'(len_reg) - rank_lo + ACC_W'(1);

    // samples past the last bin land in the last bin
    assign s_bin = ({24'b0, s_sample} < 32'(VALUE_BINS)) ? BIN_W'(s_sample)
                                                         : BIN_W'(VALUE_BINS - 1);

    // saturated window length from the config write
    always_comb begin
        cfg_val = 32'(cfg_wr_data);
        if (cfg_val == 32'd0) begin
            cfg_val = 32'd1;
        end else if (cfg_val > 32'(MAX_WINDOW)) begin
            cfg_val = 32'(MAX_WINDOW);
        end
    end

    // ---------------------------------------------------------------- bin chain
    // at rest cell i holds bin VALUE_BINS-1-i, so bin 0 sits at the chain end;
    // one rotation brings every bin past the head in ascending order
    logic [CNT_W-1:0] cell_q [VALUE_BINS];

    assign cell_ctrl.clear = cfg_wr_en;
    assign cell_ctrl.shift = (state_reg == ST_SCAN);
    assign head_cnt        = cell_q[VALUE_BINS-1];

    for (genvar i = 0; i < VALUE_BINS; i++) begin : g_cell
        logic [CNT_W-1:0] cnt_in;
        if (i == 0) begin : g_first
            assign cnt_in = head_wr;
        end else begin : g_rest
            assign cnt_in = cell_q[i-1];
        end
        smsd_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .cnt_in  (cnt_in),
            .cnt_out (cell_q[i])
        );
    end

    // head update: drop the leaving sample, then add the new one
    assign is_new   = (k_reg == bin_reg);
    assign is_old   = full_reg && (k_reg == old_bin);
    assign head_dec = (is_old && head_cnt != '0) ? head_cnt - CNT_W'(1) : head_cnt;
    assign head_wr  = head_dec + CNT_W'(is_new);
    assign acc_sum  = acc_reg + ACC_W'(head_cnt);

    // ---------------------------------------------------------------- sample ring
    // read the leaving sample at accept; write the new one at retire
    assign ram_wr_en = (state_reg == ST_DONE) && out_free;

    smsd_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data (bin_reg),
        .rd_en   (s_xfer),
        .rd_addr (ptr_reg),
        .rd_data (old_bin)
    );

    // ---------------------------------------------------------------- result math
    assign med_sum     = SUM_W'(lo_reg) + SUM_W'(hi_reg);
    assign med_sum_ext = {9'b0, med_sum};
    assign samp_cmp    = {{SUM_W{1'b0}}, sample_reg};
    assign sum_cmp     = {8'b0, med_sum};
    assign hit         = full_reg && (samp_cmp >= sum_cmp);
    assign ptr_inc     = LEN_W'(ptr_reg) + LEN_W'(1);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        sample_next  = sample_reg;
        bin_next     = bin_reg;
        full_next    = full_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        got_lo_next  = got_lo_reg;
        got_hi_next  = got_hi_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        m_valid_next = m_valid_reg;
        m_full_next  = m_full_reg;
        m_alert_next = m_alert_reg;
        m_twice_next = m_twice_reg;
        m_total_next = m_total_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    sample_next = s_sample;
                    bin_next    = s_bin;
                    full_next   = (fill_reg >= len_reg);
                    k_next      = '0;
                    acc_next    = '0;
                    got_lo_next = 1'b0;
                    got_hi_next = 1'b0;
                    lo_next     = BIN_W'(VALUE_BINS - 1);
                    hi_next     = BIN_W'(VALUE_BINS - 1);
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // cumulative scan on the counts before this sample's update
                acc_next = acc_sum;
                if (!got_lo_reg && acc_sum >= rank_lo) begin
                    lo_next     = k_reg;
                    got_lo_next = 1'b1;
                end
                if (!got_hi_reg && acc_sum >= rank_hi) begin
                    hi_next     = k_reg;
                    got_hi_next = 1'b1;
                end
                k_next = k_reg + BIN_W'(1);
                if (k_reg == BIN_W'(VALUE_BINS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (hit && cnt_reg != '1) begin
                        cnt_next = cnt_reg + TOTAL_W'(1);
                    end
                    if (!full_reg) begin
                        fill_next = fill_reg + LEN_W'(1);
                    end
                    ptr_next     = (ptr_inc >= len_reg) ? '0 : PTR_W'(ptr_inc);
                    m_valid_next = 1'b1;
                    m_full_next  = full_reg;
                    m_alert_next = hit;
                    m_twice_next = full_reg ? med_sum_ext[TWICE_W-1:0] : '0;
                    m_total_next = (hit && cnt_reg != '1) ? cnt_reg + TOTAL_W'(1) : cnt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // config write clears the window
        if (cfg_wr_en) begin
            len_next   = LEN_W'(cfg_val);
            ptr_next   = '0;
            fill_next  = '0;
            cnt_next   = '0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= LEN_W'(1);
            ptr_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        bin_reg     <= bin_next;
        full_reg    <= full_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        got_lo_reg  <= got_lo_next;
        got_hi_reg  <= got_hi_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        m_full_reg  <= m_full_next;
        m_alert_reg <= m_alert_next;
        m_twice_reg <= m_twice_next;
        m_total_reg <= m_total_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_window_full  = m_full_reg;
    assign m_alert        = m_alert_reg;
    assign m_twice_median = m_twice_reg;
    assign m_alert_total  = m_total_reg;

`ifndef SYNTHESIS
    // fill level never passes the window length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= len_reg)
        else $error("fill level above window length");

    // ring pointer stays inside the window
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        LEN_W'(ptr_reg) < len_reg)
        else $error("ring pointer outside window");

    // an alert is only raised against a full window
    a_alert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alert |-> m_window_full)
        else $error("alert without full window");

    // alert count only grows between config writes
    a_cnt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_wr_en |=> cnt_reg >= $past(cnt_reg))
        else $error("alert count went down");

    // a retire with a free output slot presents a result next cycle
    a_retire: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free && !cfg_wr_en |=> m_valid && state_reg == ST_IDLE)
        else $error("retire did not load the output register");
`endif

endmodule
